>>> sv/lpe_pkg.sv
package lpe_pkg;

  // Number format and field widths
  localparam int FRAC_BITS  = 16;
  localparam int MAX_DEGREE = 63;
  localparam int DEG_W      = 6;
  localparam int X_W        = 32;
  localparam int VAL_W      = 48;

  // Step counter k runs 2..degree+1
  localparam int K_W        = DEG_W + 1;
  // Signed ((2k-1) << FRAC_BITS) - x, and its magnitude
  localparam int COEF_W     = X_W + 2;
  localparam int CMAG_W     = 32;
  // Shared multiplier: value magnitude times one digit
  localparam int DIG_W      = 16;
  localparam int PROD_W     = VAL_W + DIG_W;
  // Numerator at 2*FRAC_BITS fraction bits, with sign
  localparam int ACC_W      = 84;
  // Numerator magnitude with FRAC_BITS dropped, divided by k
  localparam int DVD_W      = 66;
  localparam int REM_W      = K_W;
  localparam int DIV_STEPS  = DVD_W / 2;
  localparam int DCNT_W     = $clog2(DIV_STEPS);

  localparam logic [DEG_W+1:0] MAX_DEG_LIM = (DEG_W + 2)'(MAX_DEGREE);

  localparam logic signed [VAL_W-1:0] ONE_FX  = VAL_W'(1) << FRAC_BITS;
  localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TEST,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_MUL_T,
    ST_SIGN,
    ST_SUB,
    ST_ABS,
    ST_DIV,
    ST_STEP,
    ST_FIN
  } lpe_state_t;

  typedef struct packed {
    logic load;
    logic test;
    logic mul_lo;
    logic mul_hi;
    logic mul_t;
    logic sign;
    logic sub;
    logic absval;
    logic div;
    logic step;
    logic out_load;
  } lpe_cmd_t;

  typedef struct packed {
    logic more;
    logic div_last;
  } lpe_sts_t;

endpackage

>>> sv/lpe_ctrl.sv
module lpe_ctrl import lpe_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  lpe_sts_t sts,
  output lpe_cmd_t cmd
);

  lpe_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       slot_free;

  assign slot_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_valid) state_nxt = ST_TEST;
      ST_TEST:   state_nxt = sts.more ? ST_MUL_LO : ST_FIN;
      ST_MUL_LO: state_nxt = ST_MUL_HI;
      ST_MUL_HI: state_nxt = ST_MUL_T;
      ST_MUL_T:  state_nxt = ST_SIGN;
      ST_SIGN:   state_nxt = ST_SUB;
      ST_SUB:    state_nxt = ST_ABS;
      ST_ABS:    state_nxt = ST_DIV;
      ST_DIV:    if (sts.div_last) state_nxt = ST_STEP;
      ST_STEP:   state_nxt = ST_TEST;
      ST_FIN:    if (slot_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_TEST:   cmd.test   = 1'b1;
      ST_MUL_LO: cmd.mul_lo = 1'b1;
      ST_MUL_HI: cmd.mul_hi = 1'b1;
      ST_MUL_T:  cmd.mul_t  = 1'b1;
      ST_SIGN:   cmd.sign   = 1'b1;
      ST_SUB:    cmd.sub    = 1'b1;
      ST_ABS:    cmd.absval = 1'b1;
      ST_DIV:    cmd.div    = 1'b1;
      ST_STEP:   cmd.step   = 1'b1;
      ST_FIN:    cmd.out_load = slot_free;
      default: begin
        cmd      = '0;
        in_ready = 1'b0;
      end
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

>>> sv/lpe_dpath.sv
module lpe_dpath import lpe_pkg::*; (
  input  logic                    clk,
  input  lpe_cmd_t                cmd,
  output lpe_sts_t                sts,
  input  logic [DEG_W-1:0]        in_degree,
  input  logic signed [X_W-1:0]   in_x_point,
  output logic signed [VAL_W-1:0] out_poly_value,
  output logic                    out_overflowed
);

  logic signed [X_W-1:0]   x_r;
  logic [DEG_W-1:0]        deg_r;
  logic [K_W-1:0]          k_r;
  logic signed [VAL_W-1:0] l0_r, l1_r;
  logic                    ovf_r;
  logic [CMAG_W-1:0]       cmag_r;
  logic [VAL_W-1:0]        pmag_r, p2mag_r;
  logic                    pneg_r, p2neg_r;
  logic [PROD_W-1:0]       prod_r;
  logic [ACC_W-1:0]        acc_r, q_r;
  logic [DVD_W-1:0]        dvd_r;
  logic [REM_W-1:0]        rem_r;
  logic [DCNT_W-1:0]       dcnt_r;
  logic                    nneg_r;
  logic signed [VAL_W-1:0] out_val_r;
  logic                    out_ovf_r;

  // Input capture
  logic                    deg_clip;
  logic [DEG_W-1:0]        deg_in;

  assign deg_clip = {2'b00, in_degree} > MAX_DEG_LIM;
  assign deg_in   = deg_clip ? MAX_DEG_LIM[DEG_W-1:0] : in_degree;

  // Coefficient magnitude: |((2k-1) << FRAC_BITS) - x|
  logic [K_W:0]              two_k_m1;
  logic signed [COEF_W-1:0]  c_val, x_ext, d_cx, d_xc;
  logic                      cneg;

  assign two_k_m1 = {k_r, 1'b0} - (K_W + 1)'(1);
  assign c_val    = COEF_W'({two_k_m1, {FRAC_BITS{1'b0}}});
  assign x_ext    = COEF_W'(x_r);
  assign d_cx     = c_val - x_ext;
  assign d_xc     = x_ext - c_val;
  assign cneg     = d_cx[COEF_W-1];

  // Shared multiplier, one 16-bit digit per pass
  logic [VAL_W-1:0]  mul_a;
  logic [DIG_W-1:0]  mul_b;
  logic [PROD_W-1:0] mul_p;
  logic [K_W-1:0]    k_m1;

  assign k_m1  = k_r - K_W'(1);
  assign mul_a = cmd.mul_t ? p2mag_r : pmag_r;

  always_comb begin
    mul_b = cmag_r[DIG_W-1:0];
    if (cmd.mul_hi) begin
      mul_b = cmag_r[2*DIG_W-1:DIG_W];
    end else if (cmd.mul_t) begin
      mul_b = DIG_W'(k_m1);
    end
  end

  assign mul_p = mul_a * mul_b;

  // Numerator magnitude
  logic [ACC_W-1:0] acc_mag;
  assign acc_mag = acc_r[ACC_W-1] ? (~acc_r + ACC_W'(1)) : acc_r;

  // Two restoring division steps per cycle by k
  logic [REM_W:0]   t1, t2;
  logic [REM_W-1:0] r1, r2;
  logic             b1, b2;

  always_comb begin
    t1 = {rem_r, dvd_r[DVD_W-1]};
    b1 = t1 >= {1'b0, k_r};
    r1 = b1 ? REM_W'(t1 - {1'b0, k_r}) : REM_W'(t1);
    t2 = {r1, dvd_r[DVD_W-2]};
    b2 = t2 >= {1'b0, k_r};
    r2 = b2 ? REM_W'(t2 - {1'b0, k_r}) : REM_W'(t2);
  end

  // Signed, saturated quotient
  logic                    neg_sat, pos_sat, step_sat;
  logic signed [VAL_W-1:0] step_val;

  always_comb begin
    neg_sat = (|dvd_r[DVD_W-1:VAL_W]) || (dvd_r[VAL_W-1] && (|dvd_r[VAL_W-2:0]));
    pos_sat = |dvd_r[DVD_W-1:VAL_W-1];
    if (nneg_r) begin
      step_sat = neg_sat;
      step_val = neg_sat ? VAL_MIN : -$signed(dvd_r[VAL_W-1:0]);
    end else begin
      step_sat = pos_sat;
      step_val = pos_sat ? VAL_MAX : $signed(dvd_r[VAL_W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_r   <= in_x_point;
      deg_r <= deg_in;
      k_r   <= K_W'(2);
      ovf_r <= 1'b0;
      l0_r  <= ONE_FX;
      l1_r  <= (deg_in == '0) ? ONE_FX : ONE_FX - VAL_W'(in_x_point);
    end
    if (cmd.test) begin
      cmag_r  <= cneg ? d_xc[CMAG_W-1:0] : d_cx[CMAG_W-1:0];
      pneg_r  <= cneg ^ l1_r[VAL_W-1];
      p2neg_r <= l0_r[VAL_W-1];
      pmag_r  <= l1_r[VAL_W-1] ? VAL_W'(-l1_r) : VAL_W'(l1_r);
      p2mag_r <= l0_r[VAL_W-1] ? VAL_W'(-l0_r) : VAL_W'(l0_r);
    end
    if (cmd.mul_lo || cmd.mul_hi || cmd.mul_t) begin
      prod_r <= mul_p;
    end
    if (cmd.mul_hi) begin
      acc_r <= ACC_W'(prod_r);
    end
    if (cmd.mul_t) begin
      acc_r <= acc_r + ACC_W'({prod_r, {DIG_W{1'b0}}});
    end
    if (cmd.sign) begin
      acc_r <= pneg_r ? (~acc_r + ACC_W'(1)) : acc_r;
      q_r   <= p2neg_r ? (~ACC_W'({prod_r, {FRAC_BITS{1'b0}}}) + ACC_W'(1))
                       : ACC_W'({prod_r, {FRAC_BITS{1'b0}}});
    end
    if (cmd.sub) begin
      acc_r <= acc_r - q_r;
    end
    if (cmd.absval) begin
      nneg_r <= acc_r[ACC_W-1];
      dvd_r  <= acc_mag[FRAC_BITS +: DVD_W];
      rem_r  <= '0;
      dcnt_r <= '0;
    end
    if (cmd.div) begin
      dvd_r  <= {dvd_r[DVD_W-3:0], b1, b2};
      rem_r  <= r2;
      dcnt_r <= dcnt_r + DCNT_W'(1);
    end
    if (cmd.step) begin
      l0_r  <= l1_r;
      l1_r  <= step_val;
      ovf_r <= ovf_r | step_sat;
      k_r   <= k_r + K_W'(1);
    end
    if (cmd.out_load) begin
      out_val_r <= l1_r;
      out_ovf_r <= ovf_r;
    end
  end

  assign sts.more     = k_r <= {1'b0, deg_r};
  assign sts.div_last = dcnt_r == DCNT_W'(DIV_STEPS - 1);

  assign out_poly_value = out_val_r;
  assign out_overflowed = out_ovf_r;

endmodule

>>> sv/laguerre_polynomial_eval.sv
// Laguerre polynomial evaluator. Each input word gives a degree n (clipped to
// MAX_DEGREE) and a point x in signed fixed point with 16 fraction bits; the
// result word gives L_n(x) in the same format, saturated to 48 bits, with an
// overflow flag that is set when any step of the recurrence saturated. The
// block works on one word at a time: the recurrence
// L_k = ((2k-1-x)L_{k-1} - (k-1)L_{k-2}) / k runs once per k from 2 to n, and
// each step passes through TEST, MUL_LO, MUL_HI, MUL_T, SIGN, SUB and ABS on
// the shared 48x16 multiplier and the numerator, then DIV in a radix-4
// restoring divider by k, and STEP to saturate and advance. A finished result
// waits in the output register, so a new word is taken in while the previous
// result is still unclaimed; the next result holds in the block until that
// register is free.
module laguerre_polynomial_eval import lpe_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [DEG_W-1:0]        in_degree,
  input  logic signed [X_W-1:0]   in_x_point,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [VAL_W-1:0] out_poly_value,
  output logic                    out_overflowed
);

  lpe_cmd_t cmd;
  lpe_sts_t sts;

  // Sequencer: accept, step through the recurrence, hand off the result
  lpe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Arithmetic, recurrence state and the output register
  lpe_dpath u_dpath (
    .clk            (clk),
    .cmd            (cmd),
    .sts            (sts),
    .in_degree      (in_degree),
    .in_x_point     (in_x_point),
    .out_poly_value (out_poly_value),
    .out_overflowed (out_overflowed)
  );

endmodule

>>> sv/lpe_checker.sv
module lpe_checker import lpe_pkg::*; (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic signed [VAL_W-1:0] out_poly_value,
  input logic                    out_overflowed
);

  // Words taken in but not yet delivered
  logic [1:0] pend_r, pend_nxt;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  always_comb begin
    pend_nxt = pend_r;
    if (in_acc && !out_acc) begin
      pend_nxt = pend_r + 2'd1;
    end else if (!in_acc && out_acc) begin
      pend_nxt = pend_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 2'd0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  // One word at a time in the arithmetic
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ready)
    else $error("in_ready held high after a word was accepted");

  // A result word only for a word taken in
  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 2'd0)
    else $error("result shown with no word outstanding");

  // At most one word working and one waiting at the output
  a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r != 2'd3)
    else $error("more than two words outstanding");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_poly_value)
      && $stable(out_overflowed))
    else $error("stalled result word changed or dropped");

endmodule

bind laguerre_polynomial_eval lpe_checker u_lpe_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_poly_value (out_poly_value),
  .out_overflowed (out_overflowed)
);
